FILE: sv/ascs_pkg.sv
`default_nettype none
package ascs_pkg;

  localparam int LIMIT_W = 13;
  localparam int MASK_W = 7;
  localparam int TAG_W = 4;
  localparam int VALUE_W = 12;
  localparam int CHAN_W = 3;
  localparam int INDEX_W = 12;

  // Configuration register indexes.
  localparam logic [1:0] REG_FETCH_LIMIT = 2'd0;
  localparam logic [1:0] REG_BUFFER_LIMIT = 2'd1;
  localparam logic [1:0] REG_CHANNEL_MASK = 2'd2;

  // Job kinds handed from the front end to the back end.
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_BAD = 2'd2;
  localparam logic [1:0] KIND_NOCHAN = 2'd3;

  typedef struct packed {
    logic                cmd;
    logic [TAG_W-1:0]    channel_tag;
    logic [VALUE_W-1:0]  sample_value;
  } in_item_t;

  typedef struct packed {
    logic                store_valid;
    logic [CHAN_W-1:0]   store_channel;
    logic [INDEX_W-1:0]  store_index;
    logic [VALUE_W-1:0]  store_value;
    logic [MASK_W-1:0]   active_channels;
    logic                run_done;
    logic                bad_tag;
  } out_item_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [CHAN_W-1:0]   chan;
    logic [VALUE_W-1:0]  value;
  } job_t;

  typedef struct packed {
    logic [LIMIT_W-1:0]  fetch_limit;
    logic [LIMIT_W-1:0]  buffer_limit;
    logic [MASK_W-1:0]   channel_mask;
  } cfg_t;

endpackage
`default_nettype wire

FILE: sv/ascs_queue.sv
`default_nettype none
module ascs_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  empty,
  output logic [WIDTH-1:0]      pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic do_push, do_pop;

  assign full = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

FILE: sv/ascs_front.sv
`default_nettype none
module ascs_front
  import ascs_pkg::*;
#(
  parameter int CHANNELS = 7
) (
  input  wire in_item_t item,
  output job_t          job
);

  // Only the first seven channels have a mask bit and a buffer.
  localparam int NCH = (CHANNELS < MASK_W) ? CHANNELS : MASK_W;

  always_comb begin
    job.chan = item.channel_tag[CHAN_W-1:0];
    job.value = item.sample_value;
    if (!item.cmd) begin
      job.kind = KIND_START;
    end else if ({1'b0, item.channel_tag} >= (TAG_W + 1)'(CHANNELS)) begin
      job.kind = KIND_BAD;
    end else if ({1'b0, item.channel_tag} >= (TAG_W + 1)'(NCH)) begin
      job.kind = KIND_NOCHAN;
    end else begin
      job.kind = KIND_SAMPLE;
    end
  end

endmodule
`default_nettype wire

FILE: sv/ascs_back.sv
`default_nettype none
module ascs_back
  import ascs_pkg::*;
#(
  parameter int CHANNELS = 7,
  parameter int MAX_SAMPLES = 4096
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cfg_t      cfg,
  input  wire logic      job_valid,
  input  wire job_t      job,
  output logic           job_take,
  input  wire logic      res_full,
  output logic           res_push,
  output out_item_t      res
);

  localparam int NCH = (CHANNELS < MASK_W) ? CHANNELS : MASK_W;
  localparam int IDX_W = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int MAX_LIM = (MAX_SAMPLES > 8191) ? 8191 : MAX_SAMPLES;
  localparam logic [MASK_W-1:0] CHAN_BITS = MASK_W'((1 << NCH) - 1);

  logic [LIMIT_W-1:0] counts_r [NCH];
  logic [MASK_W-1:0]  act_r, act_nxt;
  logic [LIMIT_W-1:0] lim, lim_a;
  logic [LIMIT_W-1:0] cnt, cnt_inc;
  logic [IDX_W-1:0]   idx;
  logic               cnt_write;

  assign job_take = job_valid && !res_full;
  assign res_push = job_take;
  assign idx = job.chan[IDX_W-1:0];
  assign cnt = counts_r[idx];
  assign cnt_inc = cnt + LIMIT_W'(1);

  always_comb begin
    lim_a = (cfg.buffer_limit < cfg.fetch_limit) ? cfg.buffer_limit : cfg.fetch_limit;
    lim = (lim_a > LIMIT_W'(MAX_LIM)) ? LIMIT_W'(MAX_LIM) : lim_a;
  end

  always_comb begin
    act_nxt = act_r;
    cnt_write = 1'b0;
    res = '0;
    case (job.kind)
      KIND_START: begin
        act_nxt = cfg.channel_mask & CHAN_BITS;
      end
      KIND_BAD: begin
        res.bad_tag = 1'b1;
      end
      KIND_SAMPLE: begin
        if (act_r[job.chan]) begin
          if (cnt < lim) begin
            cnt_write = 1'b1;
            res.store_valid = 1'b1;
            res.store_channel = job.chan;
            res.store_index = cnt[INDEX_W-1:0];
            res.store_value = job.value;
            if (cnt_inc >= lim) begin
              act_nxt[job.chan] = 1'b0;
            end
          end else begin
            act_nxt[job.chan] = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
    res.active_channels = act_nxt;
    res.run_done = (act_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= '0;
      for (int i = 0; i < NCH; i++) begin
        counts_r[i] <= '0;
      end
    end else if (job_take) begin
      act_r <= act_nxt;
      if (job.kind == KIND_START) begin
        for (int i = 0; i < NCH; i++) begin
          counts_r[i] <= '0;
        end
      end else if (cnt_write) begin
        counts_r[idx] <= cnt_inc;
      end
    end
  end

endmodule
`default_nettype wire

FILE: sv/adc_sample_channel_sorter_core.sv
`default_nettype none
// Channel   Ports                                   Direction  Transaction when
// input     in_push, in_full, in_data               in         in_push && !in_full
// result    out_pop, out_empty, out_data            out        out_pop && !out_empty
// config    cfg_we, cfg_index, cfg_wdata            in         cfg_we
//
// Every input transaction yields exactly one result transaction.
// An accepted transaction passes through the job queue and the back end into
// the result queue, from which it can be popped; one is accepted per cycle
// when results are popped as fast as they appear.
// The rate is set by the count read-modify-write in the back end.
// Reset (rst_n low, synchronous) empties both queues, clears all counts, the
// active set and the configuration registers; the block is ready at once.
// Each side stalls on its own: in_full rises only when the job queue is full.
module adc_sample_channel_sorter_core
  import ascs_pkg::*;
#(
  parameter int CHANNELS = 7,
  parameter int MAX_SAMPLES = 4096
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire in_item_t           in_data,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output out_item_t               out_data,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [LIMIT_W-1:0] cfg_wdata
);

  localparam int JOB_W = $bits(job_t);
  localparam int RES_W = $bits(out_item_t);
  localparam int NCH = (CHANNELS < MASK_W) ? CHANNELS : MASK_W;
  localparam logic [MASK_W-1:0] CHAN_BITS = MASK_W'((1 << NCH) - 1);

  cfg_t cfg_r;

  job_t      front_job;
  job_t      mid_job;
  logic      mid_empty;
  logic      mid_pop;
  logic      res_full;
  logic      res_push;
  out_item_t res_item;
  logic [RES_W-1:0] out_bits;

  // Configuration registers. Writes must land only while the block is idle (the
  // block does not enforce this), as the back end uses them without shadow copies.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FETCH_LIMIT: cfg_r.fetch_limit <= cfg_wdata;
        REG_BUFFER_LIMIT: cfg_r.buffer_limit <= cfg_wdata;
        REG_CHANNEL_MASK: cfg_r.channel_mask <= cfg_wdata[MASK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The front end sorts each word into a start, a sample, a bad tag or a
  // channel that has no mask bit, and drops it into the job queue.
  ascs_front #(
    .CHANNELS(CHANNELS)
  ) u_front (
    .item(in_data),
    .job (front_job)
  );

  ascs_queue #(
    .WIDTH(JOB_W),
    .DEPTH(2)
  ) u_job_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_push),
    .push_data(front_job),
    .full     (in_full),
    .pop      (mid_pop),
    .empty    (mid_empty),
    .pop_data (mid_job)
  );

  // The back end owns the per-channel counts and the active set and builds
  // one result per job.
  ascs_back #(
    .CHANNELS   (CHANNELS),
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .job_valid(!mid_empty),
    .job      (mid_job),
    .job_take (mid_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res_item)
  );

  // The result queue decouples the back end from the consumer.
  ascs_queue #(
    .WIDTH(RES_W),
    .DEPTH(2)
  ) u_res_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_push),
    .push_data(res_item),
    .full     (res_full),
    .pop      (out_pop),
    .empty    (out_empty),
    .pop_data (out_bits)
  );

  assign out_data = out_item_t'(out_bits);

`ifndef NO_ASSERTIONS
  // run_done must agree with the active set it travels with.
  a_done_matches: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_data.run_done == (out_data.active_channels == '0)))
    else $error("run_done disagrees with active_channels");

  // A bad tag never produces a store.
  a_bad_no_store: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.bad_tag) |-> !out_data.store_valid)
    else $error("store issued for a bad tag");

  // The active set never holds a channel that does not exist.
  a_act_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> ((out_data.active_channels & ~CHAN_BITS) == '0))
    else $error("active set holds a nonexistent channel");

  // A job leaving the job queue always produces a result in the same cycle.
  a_job_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    mid_pop |-> (res_push && !res_full))
    else $error("job consumed without a result");
`endif

endmodule
`default_nettype wire

FILE: sim/tb.sv
`default_nettype none
// Testbench for the ADC sample channel sorter.
//
// Stimulus goes in through the input queue port. A behavioral model of the
// sorter (per-channel fill counts, the live channel set and the three
// configuration registers) runs beside the design. Every accepted input
// transaction produces one expected result transaction, which is queued and
// compared field by field against the next result popped from the design.
//
// The run has three parts:
//   - a short directed table covering reset state, bad tags, a zero limit,
//     limit drop-out, inactive channels and the field extremes,
//   - random phases, each with its own register setting, where most words
//     are samples on valid channels and a few are start commands or bad tags,
//   - one longer run on a single channel with both limits programmed above
//     the sample ceiling, so the ceiling itself is the limit in force.
// Registers are only written after all expected results have been popped.
module tb;
  import ascs_pkg::*;

  localparam int NCHAN = 7;
  localparam logic [LIMIT_W-1:0] MAX_FILL = 13'd4096;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_PHASES = 9;
  localparam int WORDS_PER_PHASE = 70;
  localparam int DEEP_WORDS = 300;
  localparam int MAX_PRINTED = 40;

  // Command codes carried in the cmd field of an input word.
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_e;

  // One row of the directed table: either an input word (optionally with a
  // hand-written expected result) or a full register setting.
  typedef struct {
    row_kind_e          kind;
    in_item_t           word;
    bit                 known;
    out_item_t          want;
    logic [LIMIT_W-1:0] fetch;
    logic [LIMIT_W-1:0] buffer;
    logic [MASK_W-1:0]  mask;
  } dir_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_push;
  logic               in_full;
  in_item_t           in_data;
  logic               out_empty;
  logic               out_pop;
  out_item_t          out_data;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [LIMIT_W-1:0] cfg_wdata;

  // Model state.
  logic [LIMIT_W-1:0] fill_count [NCHAN];
  logic [MASK_W-1:0]  live_set;
  logic [LIMIT_W-1:0] fetch_lim;
  logic [LIMIT_W-1:0] buffer_lim;
  logic [MASK_W-1:0]  mask_reg;

  out_item_t pending_stores [$];
  int        mismatch_count;
  int        result_count;
  int        cycle_count;

  // Side information for the word currently on in_data: when word_known is
  // set, word_want replaces the model's answer as the expectation.
  bit        word_known;
  out_item_t word_want;

  // Sender burst state and receiver stall pattern state.
  int        burst_left;
  int        pop_mode;
  int        pop_mode_left;
  int        pop_tick;

  // Register settings for the fixed random phases; the later ones are drawn
  // at random. The extremes of every register appear here: limits of zero,
  // the sample ceiling and the top of the 13-bit range, and masks of none
  // and all channels.
  logic [LIMIT_W-1:0] phase_fetch  [5] = '{13'd8191, 13'd4,    13'd0, 13'd1, 13'd7};
  logic [LIMIT_W-1:0] phase_buffer [5] = '{13'd5,    13'd4096, 13'd0, 13'd1, 13'd9};
  logic [MASK_W-1:0]  phase_mask   [5] = '{7'h7F,    7'h2A,    7'h7F, 7'h55, 7'h00};

  adc_sample_channel_sorter_core #(
    .CHANNELS(NCHAN),
    .MAX_SAMPLES(4096)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_push(in_push),
    .in_full(in_full),
    .in_data(in_data),
    .out_empty(out_empty),
    .out_pop(out_pop),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Clear the model to its reset state.
  function automatic void clear_model();
    for (int c = 0; c < NCHAN; c++) begin
      fill_count[c] = '0;
    end
    live_set = '0;
    fetch_lim = '0;
    buffer_lim = '0;
    mask_reg = '0;
  endfunction

  // Model of the sorter: advances the model state by one input word and
  // returns the store request and status that the word should produce.
  function automatic out_item_t sort_word(input in_item_t w);
    out_item_t          r;
    logic [LIMIT_W-1:0] lim;
    logic [LIMIT_W-1:0] cnt;
    logic [CHAN_W-1:0]  ch;
    r = '0;
    ch = w.channel_tag[CHAN_W-1:0];
    if (w.cmd == CMD_START) begin
      // A start wipes the counts and reloads the live set; the tag and
      // value of the word play no part.
      for (int c = 0; c < NCHAN; c++) begin
        fill_count[c] = '0;
      end
      live_set = mask_reg;
    end else if (w.channel_tag >= NCHAN) begin
      r.bad_tag = 1'b1;
    end else if (live_set[ch]) begin
      // The limit in force is the smallest of both registers and the
      // sample ceiling.
      lim = fetch_lim;
      if (buffer_lim < lim) begin
        lim = buffer_lim;
      end
      if (MAX_FILL < lim) begin
        lim = MAX_FILL;
      end
      cnt = fill_count[ch];
      if (cnt < lim) begin
        r.store_valid = 1'b1;
        r.store_channel = ch;
        r.store_index = cnt[INDEX_W-1:0];
        r.store_value = w.sample_value;
        cnt = cnt + 1'b1;
        fill_count[ch] = cnt;
      end
      // A channel that has hit its limit leaves the live set, also when the
      // limit was already reached before this word (a zero limit, say).
      if (cnt >= lim) begin
        live_set[ch] = 1'b0;
      end
    end
    r.active_channels = live_set;
    r.run_done = (live_set == '0);
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) begin
      $display("[%0d] result %0d %s: got %0h, expected %0h",
               cycle_count, result_count, what, got, want);
    end
  endtask

  // Monitor. Everything is sampled at the rising edge, before the design's
  // registers update. An accepted input transaction is turned into an
  // expectation first, so the check also holds for a path with no registers.
  always @(posedge clk) begin : monitor
    out_item_t predicted;
    out_item_t want;
    if (!rst_n) begin
      clear_model();
      pending_stores.delete();
    end else begin
      if (in_push && !in_full) begin
        // The model always advances; a hand-written expectation from the
        // directed table, when present, takes the place of its answer.
        predicted = sort_word(in_data);
        pending_stores.push_back(word_known ? word_want : predicted);
      end
      if (out_pop && !out_empty) begin
        if (pending_stores.size() == 0) begin
          flag_mismatch("unexpected result", 64'(out_data), 64'd0);
        end else begin
          want = pending_stores.pop_front();
          if (out_data.store_valid !== want.store_valid)
            flag_mismatch("store_valid", 64'(out_data.store_valid), 64'(want.store_valid));
          if (out_data.store_channel !== want.store_channel)
            flag_mismatch("store_channel", 64'(out_data.store_channel),
                          64'(want.store_channel));
          if (out_data.store_index !== want.store_index)
            flag_mismatch("store_index", 64'(out_data.store_index), 64'(want.store_index));
          if (out_data.store_value !== want.store_value)
            flag_mismatch("store_value", 64'(out_data.store_value), 64'(want.store_value));
          if (out_data.active_channels !== want.active_channels)
            flag_mismatch("active_channels", 64'(out_data.active_channels),
                          64'(want.active_channels));
          if (out_data.run_done !== want.run_done)
            flag_mismatch("run_done", 64'(out_data.run_done), 64'(want.run_done));
          if (out_data.bad_tag !== want.bad_tag)
            flag_mismatch("bad_tag", 64'(out_data.bad_tag), 64'(want.bad_tag));
        end
        result_count++;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_FETCH_LIMIT:  fetch_lim = cfg_wdata;
          REG_BUFFER_LIMIT: buffer_lim = cfg_wdata;
          REG_CHANNEL_MASK: mask_reg = cfg_wdata[MASK_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver. It switches between a handful of stall patterns, each held
  // for a random stretch: always ready, coin flip, mostly stalled, and a
  // regular on-off rhythm taken from bit 2 of a tick counter. The always-ready
  // stretches give runs of back-to-back transactions.
  always @(negedge clk) begin
    pop_tick++;
    if (pop_mode_left == 0) begin
      pop_mode = $urandom_range(0, 3);
      pop_mode_left = $urandom_range(20, 120);
    end else begin
      pop_mode_left--;
    end
    case (pop_mode)
      0: out_pop = 1'b1;
      1: out_pop = 1'($urandom_range(0, 1));
      2: out_pop = ($urandom_range(0, 3) == 0);
      default: out_pop = pop_tick[2];
    endcase
  end

  // Offer one word and hold it until the design takes it. Words go out in
  // bursts; between bursts the push line may drop for a random gap while
  // the data lines carry junk.
  task automatic send_word(input in_item_t w, input bit known, input out_item_t want);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_push = 1'b0;
        repeat (gap) begin
          in_data = in_item_t'($urandom());
          @(negedge clk);
        end
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    in_push = 1'b1;
    in_data = w;
    word_known = known;
    word_want = want;
    do @(posedge clk); while (in_full);
  endtask

  // Stop pushing and wait until every expected result has been popped.
  // Since each word gives exactly one result, the design is idle then.
  task automatic drain();
    @(negedge clk);
    in_push = 1'b0;
    word_known = 1'b0;
    while (pending_stores.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Write all three registers in turn. Called at a falling
  // edge with the design idle.
  task automatic program_regs(input logic [LIMIT_W-1:0] fetch,
                              input logic [LIMIT_W-1:0] buffer,
                              input logic [MASK_W-1:0] mask);
    cfg_we = 1'b1;
    cfg_index = REG_FETCH_LIMIT;
    cfg_wdata = fetch;
    @(negedge clk);
    cfg_index = REG_BUFFER_LIMIT;
    cfg_wdata = buffer;
    @(negedge clk);
    cfg_index = REG_CHANNEL_MASK;
    cfg_wdata = LIMIT_W'(mask);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Random word: mostly samples on real channels, some bad tags, now and
  // then a start command, with the value extremes showing up often.
  function automatic in_item_t random_word();
    in_item_t w;
    w.cmd = ($urandom_range(0, 29) == 0) ? CMD_START : CMD_SAMPLE;
    if ($urandom_range(0, 6) == 0)
      w.channel_tag = TAG_W'($urandom_range(NCHAN, 15));
    else
      w.channel_tag = TAG_W'($urandom_range(0, NCHAN - 1));
    case ($urandom_range(0, 9))
      0: w.sample_value = '0;
      1: w.sample_value = '1;
      default: w.sample_value = VALUE_W'($urandom());
    endcase
    return w;
  endfunction

  function automatic dir_row_t word_row(input in_item_t w);
    dir_row_t r;
    r = '{kind: ROW_WORD, word: w, known: 1'b0, want: '0,
          fetch: '0, buffer: '0, mask: '0};
    return r;
  endfunction

  function automatic dir_row_t known_row(input in_item_t w, input out_item_t want);
    dir_row_t r;
    r = word_row(w);
    r.known = 1'b1;
    r.want = want;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(input logic [LIMIT_W-1:0] fetch,
                                       input logic [LIMIT_W-1:0] buffer,
                                       input logic [MASK_W-1:0] mask);
    dir_row_t r;
    r = '{kind: ROW_CFG, word: '0, known: 1'b0, want: '0,
          fetch: fetch, buffer: buffer, mask: mask};
    return r;
  endfunction

  initial begin : stimulus
    dir_row_t   directed_rows [$];
    dir_row_t   row;
    in_item_t   w;
    logic [LIMIT_W-1:0] fetch;
    logic [LIMIT_W-1:0] buffer;

    // Every input is at a known level from time zero.
    rst_n = 1'b0;
    in_push = 1'b0;
    in_data = '0;
    out_pop = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_FETCH_LIMIT;
    cfg_wdata = '0;
    word_known = 1'b0;
    word_want = '0;
    mismatch_count = 0;
    result_count = 0;
    cycle_count = 0;
    burst_left = 0;
    pop_mode = 0;
    pop_mode_left = 0;
    pop_tick = 0;
    clear_model();

    // Result field order: valid, channel, index, value, active, done, bad.
    // Straight out of reset: nothing is live, so a sample is ignored and a
    // start with an empty mask leaves the run finished.
    directed_rows.push_back(known_row('{CMD_SAMPLE, 4'd0, 12'h000},
                                      '{1'b0, 3'd0, 12'd0, 12'h000, 7'h00, 1'b1, 1'b0}));
    directed_rows.push_back(known_row('{CMD_START, 4'd0, 12'h000},
                                      '{1'b0, 3'd0, 12'd0, 12'h000, 7'h00, 1'b1, 1'b0}));
    // Tags past the last channel are flagged, including the top tag.
    directed_rows.push_back(known_row('{CMD_SAMPLE, 4'd15, 12'hFFF},
                                      '{1'b0, 3'd0, 12'd0, 12'h000, 7'h00, 1'b1, 1'b1}));
    directed_rows.push_back(known_row('{CMD_SAMPLE, 4'd7, 12'hABC},
                                      '{1'b0, 3'd0, 12'd0, 12'h000, 7'h00, 1'b1, 1'b1}));
    // Zero fetch limit: a live channel is dropped on its first sample
    // without storing anything.
    directed_rows.push_back(cfg_row(13'd0, 13'd4096, 7'h7F));
    directed_rows.push_back(known_row('{CMD_START, 4'd0, 12'h000},
                                      '{1'b0, 3'd0, 12'd0, 12'h000, 7'h7F, 1'b0, 1'b0}));
    directed_rows.push_back(known_row('{CMD_SAMPLE, 4'd3, 12'h005},
                                      '{1'b0, 3'd0, 12'd0, 12'h000, 7'h77, 1'b0, 1'b0}));
    // Limit of two on channels 0 and 6; the buffer limit sits at the top of
    // its range and must not matter.
    directed_rows.push_back(cfg_row(13'd2, 13'd8191, 7'h41));
    directed_rows.push_back(known_row('{CMD_START, 4'd0, 12'h000},
                                      '{1'b0, 3'd0, 12'd0, 12'h000, 7'h41, 1'b0, 1'b0}));
    directed_rows.push_back(known_row('{CMD_SAMPLE, 4'd6, 12'hFFF},
                                      '{1'b1, 3'd6, 12'd0, 12'hFFF, 7'h41, 1'b0, 1'b0}));
    directed_rows.push_back(known_row('{CMD_SAMPLE, 4'd6, 12'h000},
                                      '{1'b1, 3'd6, 12'd1, 12'h000, 7'h01, 1'b0, 1'b0}));
    // Channel 6 is full and channel 1 never took part.
    directed_rows.push_back(word_row('{CMD_SAMPLE, 4'd6, 12'h555}));
    directed_rows.push_back(word_row('{CMD_SAMPLE, 4'd1, 12'h2AA}));
    directed_rows.push_back(known_row('{CMD_SAMPLE, 4'd0, 12'hFFF},
                                      '{1'b1, 3'd0, 12'd0, 12'hFFF, 7'h01, 1'b0, 1'b0}));
    // A start carrying a junk tag and value still restarts the run.
    directed_rows.push_back(known_row('{CMD_START, 4'd15, 12'hFFF},
                                      '{1'b0, 3'd0, 12'd0, 12'h000, 7'h41, 1'b0, 1'b0}));
    directed_rows.push_back(known_row('{CMD_SAMPLE, 4'd0, 12'h800},
                                      '{1'b1, 3'd0, 12'd0, 12'h800, 7'h41, 1'b0, 1'b0}));
    directed_rows.push_back(known_row('{CMD_SAMPLE, 4'd0, 12'h001},
                                      '{1'b1, 3'd0, 12'd1, 12'h001, 7'h40, 1'b0, 1'b0}));
    directed_rows.push_back(word_row('{CMD_SAMPLE, 4'd6, 12'h7FF}));
    directed_rows.push_back(known_row('{CMD_SAMPLE, 4'd6, 12'h3C3},
                                      '{1'b1, 3'd6, 12'd1, 12'h3C3, 7'h00, 1'b1, 1'b0}));
    directed_rows.push_back(word_row('{CMD_SAMPLE, 4'd5, 12'h123}));
    directed_rows.push_back(known_row('{CMD_SAMPLE, 4'd8, 12'h000},
                                      '{1'b0, 3'd0, 12'd0, 12'h000, 7'h00, 1'b1, 1'b1}));

    // Synchronous reset, held across rising edges and released at a falling edge.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_CFG) begin
        drain();
        program_regs(row.fetch, row.buffer, row.mask);
      end else begin
        send_word(row.word, row.known, row.want);
      end
    end

    // Random phases. Each starts from a fresh register setting and opens
    // with a start command so the run gets past the empty live set.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain();
      if (p < 5) begin
        program_regs(phase_fetch[p], phase_buffer[p], phase_mask[p]);
      end else begin
        // Mostly small limits so channels fill and drop out often; now and
        // then anything up to the top of the register range.
        fetch = ($urandom_range(0, 9) == 0) ? LIMIT_W'($urandom_range(0, 8191))
                                            : LIMIT_W'($urandom_range(0, 12));
        buffer = ($urandom_range(0, 9) == 0) ? LIMIT_W'($urandom_range(0, 8191))
                                             : LIMIT_W'($urandom_range(0, 12));
        program_regs(fetch, buffer, MASK_W'($urandom()));
      end
      w = random_word();
      w.cmd = CMD_START;
      send_word(w, 1'b0, '0);
      repeat (WORDS_PER_PHASE - 1) begin
        send_word(random_word(), 1'b0, '0);
      end
    end

    // Longer run: both limits above the sample ceiling, so the ceiling is
    // the limit in force and channel 0 keeps collecting throughout. A little
    // noise on other channels and bad tags is mixed in.
    drain();
    program_regs(13'd8191, 13'd8191, 7'h01);
    w = random_word();
    w.cmd = CMD_START;
    send_word(w, 1'b0, '0);
    repeat (DEEP_WORDS) begin
      w = random_word();
      if ($urandom_range(0, 24) != 0) begin
        w.cmd = CMD_SAMPLE;
        w.channel_tag = '0;
      end
      send_word(w, 1'b0, '0);
    end

    // Wind down: wait for the last results, then idle on so that any stray
    // result from the design can still show.
    drain();
    repeat (8) @(negedge clk);
    if (pending_stores.size() != 0) begin
      flag_mismatch("results never delivered", 64'(pending_stores.size()), 64'd0);
    end
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
